FILE: sv/sqt_pkg.sv
package sqt_pkg;

    localparam int STEPS = 16;

    localparam logic [1:0] CORNER_FIRST = 2'd0;
    localparam logic [1:0] CORNER_LAST  = 2'd3;

    localparam logic signed [17:0] ATAN [STEPS] = '{
        18'sd8192, 18'sd4836, 18'sd2555, 18'sd1297, 18'sd651, 18'sd326, 18'sd163, 18'sd81,
        18'sd41, 18'sd20, 18'sd10, 18'sd5, 18'sd3, 18'sd1, 18'sd1, 18'sd0
    };

    // CORDIC vector and the four texel dividers (0 u left, 1 u right, 2 v top, 3 v bottom)
    typedef struct packed {
        logic signed [17:0] cx;
        logic signed [17:0] cy;
        logic signed [17:0] cz;
        logic [3:0][15:0]   rem;
        logic [3:0][15:0]   quo;
        logic [3:0][15:0]   dim;
    } iter_t;

    typedef struct packed {
        logic               neg;
        logic               flip_h;
        logic               flip_v;
        logic [3:0]         dv_zero;
        logic [3:0]         dv_sat;
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic signed [48:0] oxp;
        logic signed [48:0] oyp;
        logic [31:0]        wsx;
        logic [31:0]        hsy;
        logic [63:0]        tag;
    } side_t;

    function automatic iter_t iter_step(iter_t a, int i);
        iter_t       r;
        logic [16:0] t;
        r = a;
        if (!a.cz[17]) begin
            r.cx = a.cx - (a.cy >>> i);
            r.cy = a.cy + (a.cx >>> i);
            r.cz = a.cz - ATAN[i];
        end else begin
            r.cx = a.cx + (a.cy >>> i);
            r.cy = a.cy - (a.cx >>> i);
            r.cz = a.cz + ATAN[i];
        end
        for (int j = 0; j < 4; j++) begin
            t = {a.rem[j], 1'b0};
            if (t >= {1'b0, a.dim[j]}) begin
                r.rem[j] = 16'(t - {1'b0, a.dim[j]});
                r.quo[j] = {a.quo[j][14:0], 1'b1};
            end else begin
                r.rem[j] = t[15:0];
                r.quo[j] = {a.quo[j][14:0], 1'b0};
            end
        end
        return r;
    endfunction

endpackage

FILE: sv/sprite_quad_transform.sv
// channel | dir | tdata (low bit up)                                    | tuser  | tlast
// s_      | in  | pos_x pos_y src_corner src_size tex_size origin_x     | -      | -
//         |     | origin_y scale_x scale_y angle_flip tag (338 of 344)  |        |
// m_      | out | vert_x vert_y tex_u tex_v tag_out (162 of 168)        | corner | last
// One sprite gives four vertex transactions; sustained throughput is set by the single
// result port. The pipe takes new sprites while the output buffer still emits a sprite.
// Path from input to first vertex: input stage, 16 CORDIC/divider steps, offset stage,
// four multiply and sum stages, output buffer.
// aresetn clears all valid bits and the vertex counter.
// A stall on m_ holds the pipe; s_tready falls only when the last stage is full and
// the output buffer cannot take its sprite.
module sprite_quad_transform (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [343:0] s_tdata,   // pos_x, pos_y, src_corner, src_size, tex_size, origin_x,
                                    // origin_y, scale_x, scale_y, angle_flip, tag
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [167:0] m_tdata,   // vert_x, vert_y, tex_u, tex_v, tag_out
    output logic [1:0]   m_tuser,   // corner
    output logic         m_tlast
);

    typedef struct packed {
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic [16:0]        ul;
        logic [16:0]        ur;
        logic [16:0]        vt;
        logic [16:0]        vb;
        logic [63:0]        tag;
    } pay_t;

    function automatic logic [16:0] uv_val(logic zero, logic sat, logic [15:0] q);
        if (zero) return 17'd0;
        if (sat)  return 17'd65536;
        return {1'b0, q};
    endfunction

    function automatic logic [31:0] sat32(logic signed [48:0] v);
        if (v > 49'sd2147483647)  return 32'h7fff_ffff;
        if (v < -49'sd2147483648) return 32'h8000_0000;
        return v[31:0];
    endfunction

    logic en;
    logic take;
    logic m_acc;

    // input stage
    logic [31:0]        in_sc, in_ss, in_ts;
    logic signed [31:0] in_ox, in_oy;
    logic [15:0]        in_sx, in_sy, ang, rx, ry, rw, rh, tw, th;
    logic               full;
    logic signed [17:0] num [4];
    logic [15:0]        dimv [4];
    logic [17:0]        az;
    sqt_pkg::iter_t     s1_it_next, s1_it_reg;
    sqt_pkg::side_t     s1_sd_next, s1_sd_reg;
    logic               s1_vld_reg;

    assign in_sc = s_tdata[95:64];
    assign in_ss = s_tdata[127:96];
    assign in_ts = s_tdata[159:128];
    assign in_ox = s_tdata[191:160];
    assign in_oy = s_tdata[223:192];
    assign in_sx = s_tdata[239:224];
    assign in_sy = s_tdata[255:240];
    assign ang   = s_tdata[271:256];
    assign tw    = in_ts[15:0];
    assign th    = in_ts[31:16];
    assign full  = (in_sc == '0) && (in_ss == '0);
    assign rx    = full ? 16'd0 : in_sc[15:0];
    assign ry    = full ? 16'd0 : in_sc[31:16];
    assign rw    = full ? tw : in_ss[15:0];
    assign rh    = full ? th : in_ss[31:16];
    assign az    = {2'b00, ang};

    always_comb begin
        num[0]  = $signed({2'b00, rx}) + 18'sd1;
        num[1]  = $signed({2'b00, rx}) + $signed({2'b00, rw}) - 18'sd1;
        num[2]  = $signed({2'b00, ry}) + 18'sd1;
        num[3]  = $signed({2'b00, ry}) + $signed({2'b00, rh}) - 18'sd1;
        dimv[0] = tw;
        dimv[1] = tw;
        dimv[2] = th;
        dimv[3] = th;
        s1_it_next    = '0;
        s1_sd_next    = '0;
        s1_it_next.cx = 18'sd19899;
        s1_it_next.cy = 18'sd0;
        if (ang >= 16'd16384 && ang < 16'd49152) begin
            s1_it_next.cz  = $signed(az) - 18'sd32768;
            s1_sd_next.neg = 1'b1;
        end else if (ang >= 16'd49152) begin
            s1_it_next.cz  = $signed(az) - 18'sd65536;
        end else begin
            s1_it_next.cz  = $signed(az);
        end
        for (int j = 0; j < 4; j++) begin
            s1_it_next.rem[j]     = num[j][15:0];
            s1_it_next.dim[j]     = dimv[j];
            s1_sd_next.dv_zero[j] = (dimv[j] == 16'd0) || num[j][17];
            s1_sd_next.dv_sat[j]  = num[j] >= $signed({2'b00, dimv[j]});
        end
        s1_sd_next.flip_h = s_tdata[272];
        s1_sd_next.flip_v = s_tdata[273];
        s1_sd_next.px     = s_tdata[31:0];
        s1_sd_next.py     = s_tdata[63:32];
        s1_sd_next.oxp    = in_ox * $signed({1'b0, in_sx});
        s1_sd_next.oyp    = in_oy * $signed({1'b0, in_sy});
        s1_sd_next.wsx    = {16'd0, rw} * {16'd0, in_sx};
        s1_sd_next.hsy    = {16'd0, rh} * {16'd0, in_sy};
        s1_sd_next.tag    = s_tdata[337:274];
    end

    // CORDIC and dividers
    logic           it_vld;
    sqt_pkg::iter_t it_out;
    sqt_pkg::side_t sd_out;

    sqt_iter u_iter (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (s1_vld_reg),
        .in_it     (s1_it_reg),
        .in_sd     (s1_sd_reg),
        .out_valid (it_vld),
        .out_it    (it_out),
        .out_sd    (sd_out)
    );

    // sign fix, offsets, texel clamp and flips
    logic signed [17:0] c_c_next, c_s_next, c_c_reg, c_s_reg;
    logic signed [48:0] nox, noy;
    logic signed [40:0] c_offx_reg, c_offy_reg, c_szx_reg, c_szy_reg;
    logic [16:0]        uvq [4];
    pay_t               c_pay_next, c_pay_reg;
    logic               c_vld_reg;

    always_comb begin
        c_c_next = sd_out.neg ? -it_out.cx : it_out.cx;
        c_s_next = sd_out.neg ? -it_out.cy : it_out.cy;
        nox      = -sd_out.oxp;
        noy      = -sd_out.oyp;
        for (int j = 0; j < 4; j++) begin
            uvq[j] = uv_val(sd_out.dv_zero[j], sd_out.dv_sat[j], it_out.quo[j]);
        end
        c_pay_next.px  = sd_out.px;
        c_pay_next.py  = sd_out.py;
        c_pay_next.ul  = sd_out.flip_h ? uvq[1] : uvq[0];
        c_pay_next.ur  = sd_out.flip_h ? uvq[0] : uvq[1];
        c_pay_next.vt  = sd_out.flip_v ? uvq[3] : uvq[2];
        c_pay_next.vb  = sd_out.flip_v ? uvq[2] : uvq[3];
        c_pay_next.tag = sd_out.tag;
    end

    // products
    logic signed [58:0] m1_p_reg [8];
    pay_t               m1_pay_reg;
    logic               m1_vld_reg;

    // base terms: 0 ax, 1 bx for x, 2 by for x, 3 ay, 4 bx for y, 5 by for y
    logic signed [59:0] m2_t_reg [6];
    pay_t               m2_pay_reg;
    logic               m2_vld_reg;

    logic signed [61:0] m3_x_reg [4];
    logic signed [61:0] m3_y_reg [4];
    pay_t               m3_pay_reg;
    logic               m3_vld_reg;

    logic [31:0]        m4_x_next [4];
    logic [31:0]        m4_y_next [4];
    logic [31:0]        m4_x_reg  [4];
    logic [31:0]        m4_y_reg  [4];
    logic signed [46:0] shx [4];
    logic signed [46:0] shy [4];
    pay_t               m4_pay_reg;
    logic               m4_vld_reg;

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            shx[k] = m3_x_reg[k][61:15];
            shy[k] = m3_y_reg[k][61:15];
            m4_x_next[k] = sat32(49'(m3_pay_reg.px) + 49'(shx[k]));
            m4_y_next[k] = sat32(49'(m3_pay_reg.py) + 49'(shy[k]));
        end
    end

    // output buffer
    logic [31:0] ob_x_reg [4];
    logic [31:0] ob_y_reg [4];
    pay_t        ob_pay_reg;
    logic        ob_vld_reg, ob_vld_next;
    logic [1:0]  cnt_reg, cnt_next;

    assign m_acc = m_tvalid && m_tready;
    assign take  = m4_vld_reg && (!ob_vld_reg || (m_acc && cnt_reg == sqt_pkg::CORNER_LAST));
    assign en    = !m4_vld_reg || take;
    assign s_tready = en;

    always_comb begin
        ob_vld_next = ob_vld_reg;
        cnt_next    = cnt_reg;
        if (take) begin
            ob_vld_next = 1'b1;
            cnt_next    = sqt_pkg::CORNER_FIRST;
        end else if (m_acc) begin
            ob_vld_next = (cnt_reg != sqt_pkg::CORNER_LAST);
            cnt_next    = cnt_reg + 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_vld_reg <= 1'b0;
            c_vld_reg  <= 1'b0;
            m1_vld_reg <= 1'b0;
            m2_vld_reg <= 1'b0;
            m3_vld_reg <= 1'b0;
            m4_vld_reg <= 1'b0;
            ob_vld_reg <= 1'b0;
            cnt_reg    <= sqt_pkg::CORNER_FIRST;
        end else begin
            if (en) begin
                s1_vld_reg <= s_tvalid;
                c_vld_reg  <= it_vld;
                m1_vld_reg <= c_vld_reg;
                m2_vld_reg <= m1_vld_reg;
                m3_vld_reg <= m2_vld_reg;
                m4_vld_reg <= m3_vld_reg;
            end
            ob_vld_reg <= ob_vld_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s1_it_reg  <= s1_it_next;
            s1_sd_reg  <= s1_sd_next;

            c_c_reg    <= c_c_next;
            c_s_reg    <= c_s_next;
            c_offx_reg <= nox[48:8];
            c_offy_reg <= noy[48:8];
            c_szx_reg  <= $signed({1'b0, sd_out.wsx, 8'd0});
            c_szy_reg  <= $signed({1'b0, sd_out.hsy, 8'd0});
            c_pay_reg  <= c_pay_next;

            m1_p_reg[0] <= c_offx_reg * c_c_reg;
            m1_p_reg[1] <= c_offy_reg * c_s_reg;
            m1_p_reg[2] <= c_szx_reg  * c_c_reg;
            m1_p_reg[3] <= c_szy_reg  * c_s_reg;
            m1_p_reg[4] <= c_offx_reg * c_s_reg;
            m1_p_reg[5] <= c_offy_reg * c_c_reg;
            m1_p_reg[6] <= c_szx_reg  * c_s_reg;
            m1_p_reg[7] <= c_szy_reg  * c_c_reg;
            m1_pay_reg  <= c_pay_reg;

            m2_t_reg[0] <= 60'(m1_p_reg[0]) - 60'(m1_p_reg[1]);
            m2_t_reg[1] <= 60'(m1_p_reg[2]);
            m2_t_reg[2] <= -60'(m1_p_reg[3]);
            m2_t_reg[3] <= 60'(m1_p_reg[4]) + 60'(m1_p_reg[5]);
            m2_t_reg[4] <= 60'(m1_p_reg[6]);
            m2_t_reg[5] <= 60'(m1_p_reg[7]);
            m2_pay_reg  <= m1_pay_reg;

            m3_x_reg[0] <= 62'(m2_t_reg[0]);
            m3_x_reg[1] <= 62'(m2_t_reg[0]) + 62'(m2_t_reg[1]);
            m3_x_reg[2] <= 62'(m2_t_reg[0]) + 62'(m2_t_reg[2]);
            m3_x_reg[3] <= 62'(m2_t_reg[0]) + 62'(m2_t_reg[1]) + 62'(m2_t_reg[2]);
            m3_y_reg[0] <= 62'(m2_t_reg[3]);
            m3_y_reg[1] <= 62'(m2_t_reg[3]) + 62'(m2_t_reg[4]);
            m3_y_reg[2] <= 62'(m2_t_reg[3]) + 62'(m2_t_reg[5]);
            m3_y_reg[3] <= 62'(m2_t_reg[3]) + 62'(m2_t_reg[4]) + 62'(m2_t_reg[5]);
            m3_pay_reg  <= m2_pay_reg;

            m4_x_reg    <= m4_x_next;
            m4_y_reg    <= m4_y_next;
            m4_pay_reg  <= m3_pay_reg;
        end
        if (take) begin
            ob_x_reg   <= m4_x_reg;
            ob_y_reg   <= m4_y_reg;
            ob_pay_reg <= m4_pay_reg;
        end
    end

    assign m_tvalid = ob_vld_reg;
    assign m_tuser  = cnt_reg;
    assign m_tlast  = (cnt_reg == sqt_pkg::CORNER_LAST);
    assign m_tdata  = {6'd0,
                       ob_pay_reg.tag,
                       cnt_reg[1] ? ob_pay_reg.vb : ob_pay_reg.vt,
                       cnt_reg[0] ? ob_pay_reg.ur : ob_pay_reg.ul,
                       ob_y_reg[cnt_reg],
                       ob_x_reg[cnt_reg]};

    a_ob_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        ob_vld_reg && !m_tready |=> ob_vld_reg && $stable(cnt_reg))
        else $error("vertex buffer moved while stalled");

    a_take: assert property (@(posedge aclk) disable iff (!aresetn)
        take |=> ob_vld_reg && cnt_reg == sqt_pkg::CORNER_FIRST)
        else $error("new sprite did not start at first corner");

    a_m4_keep: assert property (@(posedge aclk) disable iff (!aresetn)
        m4_vld_reg && !en |=> m4_vld_reg)
        else $error("last stage dropped a sprite");

endmodule

FILE: sv/sqt_iter.sv
module sqt_iter (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              en,
    input  logic              in_valid,
    input  sqt_pkg::iter_t    in_it,
    input  sqt_pkg::side_t    in_sd,
    output logic              out_valid,
    output sqt_pkg::iter_t    out_it,
    output sqt_pkg::side_t    out_sd
);

    logic [sqt_pkg::STEPS-1:0] vld_reg;
    logic [sqt_pkg::STEPS-1:0] vld_in;
    sqt_pkg::iter_t            it_reg  [sqt_pkg::STEPS];
    sqt_pkg::iter_t            it_in   [sqt_pkg::STEPS];
    sqt_pkg::iter_t            it_next [sqt_pkg::STEPS];
    sqt_pkg::side_t            sd_reg  [sqt_pkg::STEPS];
    sqt_pkg::side_t            sd_in   [sqt_pkg::STEPS];

    for (genvar k = 0; k < sqt_pkg::STEPS; k++) begin : g_stage
        if (k == 0) begin : g_first
            assign vld_in[k] = in_valid;
            assign it_in[k]  = in_it;
            assign sd_in[k]  = in_sd;
        end else begin : g_rest
            assign vld_in[k] = vld_reg[k-1];
            assign it_in[k]  = it_reg[k-1];
            assign sd_in[k]  = sd_reg[k-1];
        end

        assign it_next[k] = sqt_pkg::iter_step(it_in[k], k);

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[k] <= 1'b0;
            end else if (en) begin
                vld_reg[k] <= vld_in[k];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                it_reg[k] <= it_next[k];
                sd_reg[k] <= sd_in[k];
            end
        end
    end

    assign out_valid = vld_reg[sqt_pkg::STEPS-1];
    assign out_it    = it_reg[sqt_pkg::STEPS-1];
    assign out_sd    = sd_reg[sqt_pkg::STEPS-1];

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !en |=> $stable(vld_reg)) else $error("iter valid moved while stalled");

    a_reset: assert property (@(posedge aclk)
        !aresetn |=> vld_reg == '0) else $error("iter valid survived reset");

    a_rem: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid && !out_sd.dv_zero[0] && !out_sd.dv_sat[0]
            |-> out_it.rem[0] < out_it.dim[0]) else $error("divider remainder out of range");

endmodule

FILE: verif/sprite_quad_transform_tb.sv
`timescale 1ns / 1ps

module sprite_quad_transform_tb;

    typedef struct {
        logic [31:0] pos_x, pos_y, src_corner, src_size, tex_size, origin_x, origin_y;
        logic [15:0] scale_x, scale_y;
        logic [17:0] angle_flip;
        logic [63:0] tag;
    } sprite_t;

    typedef struct packed {
        logic [1:0]  corner;
        logic [31:0] vert_x;
        logic [31:0] vert_y;
        logic [16:0] tex_u;
        logic [16:0] tex_v;
        logic [63:0] tag_out;
        logic        last;
    } vertex_t;

    int n_errors = 0;

    class vertex_scoreboard;
        vertex_t pending[$];
        int      n_vertices = 0;

        function automatic logic [16:0] texel_uv(longint num, longint dim);
            longint q;
            if (dim == 0 || num < 0) return 17'd0;
            q = (num * 65536) / dim;
            return (q > 65536) ? 17'd65536 : 17'(q);
        endfunction

        function automatic longint clamp32(longint v);
            if (v > 64'sd2147483647) return 64'sd2147483647;
            if (v < -64'sd2147483648) return -64'sd2147483648;
            return v;
        endfunction

        function automatic void note(sprite_t sp);
            longint px, py, ox, oy, sx, sy, sizex, sizey, offx, offy, dx, dy;
            longint rx, ry, rw, rh, tw, th, cx, cy, nx, z;
            logic [16:0] ul, ur, vt, vb, t;
            logic        neg;
            vertex_t     v;
            px = longint'($signed(sp.pos_x));
            py = longint'($signed(sp.pos_y));
            ox = longint'($signed(sp.origin_x));
            oy = longint'($signed(sp.origin_y));
            sx = longint'(sp.scale_x); sy = longint'(sp.scale_y);
            rx = longint'(sp.src_corner[15:0]); ry = longint'(sp.src_corner[31:16]);
            rw = longint'(sp.src_size[15:0]);   rh = longint'(sp.src_size[31:16]);
            tw = longint'(sp.tex_size[15:0]);   th = longint'(sp.tex_size[31:16]);
            if (sp.src_corner == 0 && sp.src_size == 0) begin
                rx = 0; ry = 0; rw = tw; rh = th;
            end
            sizex = rw * sx * 256;
            sizey = rh * sy * 256;
            offx = (-(ox * sx)) >>> 8;
            offy = (-(oy * sy)) >>> 8;
            ul = texel_uv(rx + 1, tw);
            ur = texel_uv(rx + rw - 1, tw);
            vt = texel_uv(ry + 1, th);
            vb = texel_uv(ry + rh - 1, th);
            if (sp.angle_flip[16]) begin t = ul; ul = ur; ur = t; end
            if (sp.angle_flip[17]) begin t = vt; vt = vb; vb = t; end
            // CORDIC, half-turn reduction for quadrants two and three
            z = longint'(sp.angle_flip[15:0]);
            neg = 1'b0;
            if (z >= 16384 && z < 49152) begin
                z -= 32768; neg = 1'b1;
            end else if (z >= 49152) begin
                z -= 65536;
            end
            cx = 19899; cy = 0;
            for (int i = 0; i < 16; i++) begin
                if (z >= 0) begin
                    nx = cx - (cy >>> i); cy = cy + (cx >>> i); z -= sqt_pkg::ATAN[i];
                end else begin
                    nx = cx + (cy >>> i); cy = cy - (cx >>> i); z += sqt_pkg::ATAN[i];
                end
                cx = nx;
            end
            if (neg) begin cx = -cx; cy = -cy; end
            for (int k = 0; k < 4; k++) begin
                dx = offx + (k[0] ? sizex : 0);
                dy = offy + (k[1] ? sizey : 0);
                v.corner  = 2'(k);
                v.vert_x  = 32'(clamp32(px + ((dx * cx - dy * cy) >>> 15)));
                v.vert_y  = 32'(clamp32(py + ((dx * cy + dy * cx) >>> 15)));
                v.tex_u   = k[0] ? ur : ul;
                v.tex_v   = k[1] ? vb : vt;
                v.tag_out = sp.tag;
                v.last    = (2'(k) == sqt_pkg::CORNER_LAST);
                pending.push_back(v);
            end
        endfunction

        function automatic void check(vertex_t got);
            vertex_t e;
            n_vertices++;
            if (pending.size() == 0) begin
                n_errors++;
                if (n_errors <= 10) $display("unexpected vertex corner %0d", got.corner);
                return;
            end
            e = pending.pop_front();
            if (got != e) begin
                n_errors++;
                if (n_errors <= 10)
                    $display({"vertex mismatch: exp c%0d x%h y%h u%h v%h t%h l%b",
                              " / got c%0d x%h y%h u%h v%h t%h l%b"},
                        e.corner, e.vert_x, e.vert_y, e.tex_u, e.tex_v, e.tag_out, e.last,
                        got.corner, got.vert_x, got.vert_y, got.tex_u, got.tex_v, got.tag_out,
                        got.last);
            end
        endfunction
    endclass

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [343:0] s_tdata = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [167:0] m_tdata;
    logic [1:0]   m_tuser;
    logic         m_tlast;

    vertex_scoreboard sb = new();
    int s_idle = 0, m_stall = 0;
    int n_sprites = 0;
    longint cycles = 0;

    sprite_quad_transform uut (.*);

    always #4 aclk = ~aclk;

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > 400000) begin
            $display("timeout");
            $display("TEST FAILED");
            $finish;
        end
    end

    always @(posedge aclk) begin
        vertex_t got;
        if (aresetn && m_tvalid && m_tready) begin
            got.vert_x  = m_tdata[31:0];
            got.vert_y  = m_tdata[63:32];
            got.tex_u   = m_tdata[80:64];
            got.tex_v   = m_tdata[97:81];
            got.tag_out = m_tdata[161:98];
            got.corner  = m_tuser;
            got.last    = m_tlast;
            sb.check(got);
        end
        m_tready <= aresetn && ($urandom_range(99) >= m_stall);
    end

    task automatic send_sprite(sprite_t sp);
        if ($urandom_range(99) < s_idle) begin
            s_tvalid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < s_idle);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {6'b0, sp.tag, sp.angle_flip, sp.scale_y, sp.scale_x, sp.origin_y,
                     sp.origin_x, sp.tex_size, sp.src_size, sp.src_corner, sp.pos_y, sp.pos_x};
        do @(posedge aclk); while (!s_tready);
        sb.note(sp);
        n_sprites++;
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge aclk);
    endtask

    function automatic sprite_t rand_sprite();
        sprite_t sp;
        logic [15:0] tw, th, rx, ry;
        sp.pos_x = $urandom; sp.pos_y = $urandom;
        sp.origin_x = $urandom; sp.origin_y = $urandom;
        sp.scale_x = 16'($urandom); sp.scale_y = 16'($urandom);
        sp.src_corner = $urandom; sp.src_size = $urandom; sp.tex_size = $urandom;
        sp.angle_flip = 18'($urandom);
        sp.tag = {$urandom, $urandom};
        if ($urandom_range(99) < 75) begin
            // plausible sprite: rect inside a modest texture
            tw = 16'($urandom_range(1, 1024)); th = 16'($urandom_range(1, 1024));
            rx = 16'($urandom_range(0, tw - 1)); ry = 16'($urandom_range(0, th - 1));
            sp.tex_size = {th, tw};
            sp.src_corner = {ry, rx};
            sp.src_size = {16'($urandom_range(0, th - ry)), 16'($urandom_range(0, tw - rx))};
            if ($urandom_range(9) == 0) begin sp.src_corner = 0; sp.src_size = 0; end
            sp.scale_x = 16'($urandom_range(0, 1024));
            sp.scale_y = 16'($urandom_range(0, 1024));
            sp.pos_x = {1'b0, 15'($urandom), 16'($urandom)} - 32'h4000_0000;
            sp.pos_y = {1'b0, 15'($urandom), 16'($urandom)} - 32'h4000_0000;
            sp.origin_x = $signed(32'($urandom_range(0, 32'h0040_0000))) - 32'sh0020_0000;
            sp.origin_y = $signed(32'($urandom_range(0, 32'h0040_0000))) - 32'sh0020_0000;
        end
        return sp;
    endfunction

    initial begin
        sprite_t sp, base;
        int angles[6] = '{0, 16384, 32768, 49152, 65535, 8192};
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        base.pos_x = 32'h0064_0000; base.pos_y = 32'h0032_0000;
        base.src_corner = {16'd8, 16'd16}; base.src_size = {16'd32, 16'd32};
        base.tex_size = {16'd128, 16'd256};
        base.origin_x = 32'h0010_0000; base.origin_y = 32'h0010_0000;
        base.scale_x = 16'h0100; base.scale_y = 16'h0100;
        base.angle_flip = 18'd0; base.tag = 64'h0123_4567_89ab_cdef;
        foreach (angles[i]) begin
            sp = base; sp.angle_flip = 18'(angles[i]); send_sprite(sp);
        end
        for (int f = 1; f < 4; f++) begin
            sp = base; sp.angle_flip = {2'(f), 16'd5000}; send_sprite(sp);
        end
        sp = base; sp.src_corner = 0; sp.src_size = 0; send_sprite(sp);       // whole texture
        sp = base; sp.tex_size = {16'd64, 16'd0}; send_sprite(sp);            // zero width
        sp = base; sp.tex_size = {16'd0, 16'd64}; send_sprite(sp);            // zero height
        sp = base; sp.src_corner = 32'hFFFF_FFFF; sp.src_size = 32'hFFFF_FFFF;
        sp.tex_size = {16'd16, 16'd16}; send_sprite(sp);                      // rect off texture
        sp = base; sp.pos_x = 32'h7FFF_FFFF; sp.pos_y = 32'h8000_0000;
        sp.origin_x = 32'h8000_0000; sp.origin_y = 32'h7FFF_FFFF;
        sp.scale_x = 16'hFFFF; sp.scale_y = 16'hFFFF; sp.angle_flip = 18'h3FFFF;
        sp.src_size = 32'hFFFF_FFFF; sp.tag = '1; send_sprite(sp);           // saturation
        sp = base; sp.scale_x = 0; sp.scale_y = 0; sp.tag = 0; send_sprite(sp);
        sp = base; sp.src_size = 0; send_sprite(sp);                          // zero size rect
        sp = base; sp.tex_size = 32'hFFFF_FFFF; sp.src_corner = 32'hFFFE_FFFE;
        sp.src_size = 32'h0001_0001; send_sprite(sp);
        drain();

        for (int ph = 0; ph < 4; ph++) begin
            s_idle  = (ph == 1 || ph == 3) ? ((ph == 3) ? 32 : 68) : 0;
            m_stall = (ph == 2 || ph == 3) ? ((ph == 3) ? 32 : 68) : 0;
            for (int n = 0; n < 85; n++) begin
                send_sprite(rand_sprite());
                if (n == 40 && ph == 0) drain();
            end
            drain();
        end

        repeat (60) @(posedge aclk);
        $display("%0d sprites sent, %0d vertices checked over four idle/stall phases",
                 n_sprites, sb.n_vertices);
        if (n_errors == 0 && sb.pending.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("%0d mismatches, %0d vertices outstanding", n_errors, sb.pending.size());
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

FILE: sim.f
sv/sqt_pkg.sv
sv/sqt_iter.sv
sv/sprite_quad_transform.sv
verif/sprite_quad_transform_tb.sv
